FILE: rtl/bucketed_hash_table_engine_macros.svh
// Assertion macros shared by the hash table engine RTL.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef BUCKETED_HASH_TABLE_ENGINE_MACROS_SVH
`define BUCKETED_HASH_TABLE_ENGINE_MACROS_SVH

// Condition must hold on every enabled clock edge.
`define BHTE_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define BHTE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the clock cycle after the antecedent.
`define BHTE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/bhte_pkg.sv
// Package for the bucketed hash table engine: operation codes, FSM states,
// hash constants and the elaboration-time hash column table. No dependencies.
`timescale 1ns / 1ps

package bhte_pkg;

  localparam int KEY_W      = 32;
  localparam int VAL_W      = 32;
  localparam int HASH_STEPS = 32;

  localparam logic [KEY_W-1:0] HASH_POLY = 32'h1EDC6F41;
  localparam logic [VAL_W-1:0] ALL_ONES  = 32'hFFFFFFFF;

  // Status codes of a result word
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // Operation codes; code 3 is unused and acts as a no-op
  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_FIND   = 2'd2
  } func_t;

  // Control FSM states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_EVAL
  } state_t;

  typedef logic [KEY_W-1:0] hash_cols_t [KEY_W];

  // Shift/XOR mixer, 32 steps. Only evaluated on constants at elaboration.
  function automatic logic [KEY_W-1:0] mix_key(input logic [KEY_W-1:0] v);
    logic [KEY_W-1:0] acc;
    acc = v;
    for (int s = 0; s < HASH_STEPS; s++) begin
      if (acc[KEY_W-1]) begin
        acc = (acc << 1) ^ HASH_POLY;
      end else begin
        acc = acc << 1;
      end
    end
    return acc;
  endfunction

  // The mixer is linear over GF(2): column i is the image of key bit i.
  function automatic hash_cols_t build_hash_cols();
    hash_cols_t cols;
    for (int i = 0; i < KEY_W; i++) begin
      cols[i] = mix_key(KEY_W'(1) << i);
    end
    return cols;
  endfunction

endpackage

FILE: rtl/bhte_ram.sv
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered and holds while no read is issued. No dependencies.
`timescale 1ns / 1ps

module bhte_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/bhte_hash.sv
// Key hash and bucket index unit: GF(2) column XOR of the key, then reduction
// modulo NUM_BUCKETS. Depends on bhte_pkg.
`timescale 1ns / 1ps

module bhte_hash import bhte_pkg::*; #(
  parameter int NUM_BUCKETS = 512
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [KEY_W-1:0]               key,
  output logic                           done,
  output logic [$clog2(NUM_BUCKETS)-1:0] bucket
);

  localparam int         BW        = $clog2(NUM_BUCKETS);
  localparam bit         POW2      = ((1 << BW) == NUM_BUCKETS);
  localparam hash_cols_t HASH_COLS = build_hash_cols();

  logic [KEY_W-1:0] mixed;
  logic [KEY_W-1:0] h_r;
  logic             done_r;

  // XOR of the columns selected by the key bits
  always_comb begin
    mixed = '0;
    for (int i = 0; i < KEY_W; i++) begin
      if (key[i]) begin
        mixed = mixed ^ HASH_COLS[i];
      end
    end
  end

  generate
    if (POW2) begin : g_mask
      // Power-of-two bucket count: the bucket is the low hash bits
      always_ff @(posedge clk) begin
        if (start) begin
          h_r <= mixed;
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          done_r <= 1'b0;
        end else begin
          done_r <= start;
        end
      end

      assign bucket = h_r[BW-1:0];
    end else begin : g_mod
      // Remainder by a general constant: 8 hash bits a cycle, MSB first
      localparam int           DIGIT_W = 8;
      localparam int           NDIG    = KEY_W / DIGIT_W;
      localparam int           SW      = $clog2(NDIG + 1);
      localparam logic [BW:0]  NB_V    = (BW+1)'(NUM_BUCKETS);

      logic [SW-1:0] step_r;
      logic [BW-1:0] rem_r;
      logic [BW-1:0] rem_nxt;
      logic [BW:0]   trial;

      always_comb begin
        rem_nxt = rem_r;
        trial   = '0;
        for (int j = 0; j < DIGIT_W; j++) begin
          trial = {rem_nxt, h_r[KEY_W-1-j]};
          if (trial >= NB_V) begin
            trial = trial - NB_V;
          end
          rem_nxt = trial[BW-1:0];
        end
      end

      // Hash word shifts out one digit per step
      always_ff @(posedge clk) begin
        if (start) begin
          h_r   <= mixed;
          rem_r <= '0;
        end else if (step_r != '0) begin
          h_r   <= h_r << DIGIT_W;
          rem_r <= rem_nxt;
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          step_r <= '0;
          done_r <= 1'b0;
        end else begin
          done_r <= (step_r == SW'(1));
          if (start) begin
            step_r <= SW'(NDIG);
          end else if (step_r != '0) begin
            step_r <= step_r - SW'(1);
          end
        end
      end

      assign bucket = rem_r;
    end
  endgenerate

  assign done = done_r;

endmodule

FILE: rtl/bhte_match.sv
// Way compare for one bucket row: first valid way holding the key and first
// free way, each one-hot or all zero. Depends on bhte_pkg.
`timescale 1ns / 1ps

module bhte_match import bhte_pkg::*; #(
  parameter int WAYS = 4
) (
  input  logic [KEY_W-1:0]      key,
  input  logic [WAYS-1:0]       valid,
  input  logic [WAYS*KEY_W-1:0] keys,
  output logic [WAYS-1:0]       match_oh,
  output logic [WAYS-1:0]       free_oh
);

  logic [WAYS-1:0] eq;
  logic [WAYS-1:0] vacant;

  // Per-way compare
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      eq[w] = valid[w] && (keys[w*KEY_W +: KEY_W] == key);
    end
    vacant = ~valid;
  end

  // Lowest set bit wins
  assign match_oh = eq & (~eq + WAYS'(1));
  assign free_oh  = vacant & (~vacant + WAYS'(1));

endmodule

FILE: rtl/bucketed_hash_table_engine.sv
// An accepted input word goes through the hash unit (with an added remainder reduction
// when NUM_BUCKETS is not a power of two), the tag and value RAM row read, the bucket
// evaluation and the result register. A new word is accepted only when the previous
// one leaves ST_EVAL, which waits while a result is stalled. Reset: synchronous, active
// low; then ST_CLEAR zeroes each tag RAM row, valid bits too, with in_stall held high.
`timescale 1ns / 1ps
`include "bucketed_hash_table_engine_macros.svh"

module bucketed_hash_table_engine import bhte_pkg::*; #(
  parameter int NUM_BUCKETS = 512,
  parameter int WAYS        = 4
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // Request channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_func,
  input  logic signed [KEY_W-1:0] in_lookup_key,
  input  logic [VAL_W-1:0]        in_entry_value,
  // Result channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_hit,
  output logic [VAL_W-1:0]        out_read_value,
  output logic                    out_status
);

  localparam int BW     = $clog2(NUM_BUCKETS);
  localparam int KROW_W = WAYS * KEY_W;
  localparam int TAG_W  = WAYS + KROW_W;
  localparam int VROW_W = WAYS * VAL_W;

  state_t state_r, state_nxt;

  logic [BW-1:0]    clr_cnt_r;
  logic [1:0]       func_r;
  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] val_r;

  logic             in_acc;
  logic             eval_go;
  logic             hash_done;
  logic [BW-1:0]    bucket;

  logic             tag_we, tag_re;
  logic [BW-1:0]    tag_waddr;
  logic [TAG_W-1:0] tag_wdata, tag_rdata;
  logic             val_we;
  logic [VROW_W-1:0] val_wdata, val_rdata;

  logic [WAYS-1:0]   tag_valid;
  logic [KROW_W-1:0] tag_keys;
  logic [WAYS-1:0]   match_oh, free_oh;

  logic              is_ins, is_rem, is_find, has_match, has_free;
  logic              tag_upd;
  logic [WAYS-1:0]   new_valid, val_mask;
  logic [KROW_W-1:0] new_keys;
  logic [VAL_W-1:0]  sel_value;

  logic             out_valid_r, out_valid_nxt;
  logic             out_hit_r;
  logic [VAL_W-1:0] out_read_value_r;
  logic             out_status_r;

  assign in_acc = in_valid && !in_stall;

  // Hash and bucket index
  bhte_hash #(
    .NUM_BUCKETS (NUM_BUCKETS)
  ) u_hash (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (in_acc),
    .key    ($unsigned(in_lookup_key)),
    .done   (hash_done),
    .bucket (bucket)
  );

  // Tag RAM row: {valid per way, key per way}
  bhte_ram #(
    .WIDTH (TAG_W),
    .DEPTH (NUM_BUCKETS)
  ) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (tag_wdata),
    .re    (tag_re),
    .raddr (bucket),
    .rdata (tag_rdata)
  );

  // Value RAM row: value per way
  bhte_ram #(
    .WIDTH (VROW_W),
    .DEPTH (NUM_BUCKETS)
  ) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (bucket),
    .wdata (val_wdata),
    .re    (tag_re),
    .raddr (bucket),
    .rdata (val_rdata)
  );

  assign tag_valid = tag_rdata[TAG_W-1 -: WAYS];
  assign tag_keys  = tag_rdata[KROW_W-1:0];

  bhte_match #(
    .WAYS (WAYS)
  ) u_match (
    .key      (key_r),
    .valid    (tag_valid),
    .keys     (tag_keys),
    .match_oh (match_oh),
    .free_oh  (free_oh)
  );

  // Bucket update and result word
  always_comb begin
    is_ins    = (func_r == FUNC_INSERT);
    is_rem    = (func_r == FUNC_REMOVE);
    is_find   = (func_r == FUNC_FIND);
    has_match = |match_oh;
    has_free  = |free_oh;

    sel_value = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (match_oh[w]) begin
        sel_value = sel_value | val_rdata[w*VAL_W +: VAL_W];
      end
    end

    for (int w = 0; w < WAYS; w++) begin
      new_keys[w*KEY_W +: KEY_W] = free_oh[w] ? key_r : tag_keys[w*KEY_W +: KEY_W];
    end

    new_valid = tag_valid;
    tag_upd   = 1'b0;
    val_mask  = '0;
    if (is_ins) begin
      val_mask = has_match ? match_oh : free_oh;
      if (!has_match && has_free) begin
        new_valid = tag_valid | free_oh;
        tag_upd   = 1'b1;
      end
    end else if (is_rem && has_match) begin
      new_valid = tag_valid & ~match_oh;
      tag_upd   = 1'b1;
    end

    for (int w = 0; w < WAYS; w++) begin
      val_wdata[w*VAL_W +: VAL_W] = val_mask[w] ? val_r : val_rdata[w*VAL_W +: VAL_W];
    end
  end

  assign eval_go = (state_r == ST_EVAL) && (!out_valid_r || !out_stall);

  // Control FSM: next state and memory controls
  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b1;
    tag_re    = 1'b0;
    tag_we    = 1'b0;
    tag_waddr = bucket;
    tag_wdata = {new_valid, new_keys};
    val_we    = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        tag_we    = 1'b1;
        tag_waddr = clr_cnt_r;
        tag_wdata = '0;
        if (clr_cnt_r == BW'(NUM_BUCKETS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_nxt = ST_HASH;
        end
      end
      ST_HASH: begin
        if (hash_done) begin
          tag_re    = 1'b1;
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (eval_go) begin
          in_stall  = 1'b0;
          tag_we    = tag_upd;
          val_we    = is_ins && (has_match || has_free);
          state_nxt = in_valid ? ST_HASH : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + BW'(1);
      end
    end
  end

  // Request word capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r <= in_func;
      key_r  <= $unsigned(in_lookup_key);
      val_r  <= in_entry_value;
    end
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (eval_go) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (eval_go) begin
      out_hit_r        <= has_match && (is_ins || is_rem || is_find);
      out_read_value_r <= (is_find && has_match) ? sel_value : ALL_ONES;
      out_status_r     <= (is_ins && !has_match && !has_free) ? STATUS_FULL : STATUS_OK;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_read_value = out_read_value_r;
  assign out_status     = out_status_r;

  // Checks
  `BHTE_ASSERT_ALWAYS(a_no_rw_overlap, !(tag_we && tag_re), "tag RAM read and write overlap")
  `BHTE_ASSERT_NEXT(a_acc_to_hash, in_acc, state_r == ST_HASH, "accepted word did not start hash")
  `BHTE_ASSERT_SAME(a_match_onehot, state_r == ST_EVAL, $onehot0(match_oh), "multiple ways match")
  `BHTE_ASSERT_SAME(a_match_free_disjoint, state_r == ST_EVAL, (match_oh & free_oh) == '0,
                    "a way is both matching and free")
  `BHTE_ASSERT_SAME(a_out_from_eval, $rose(out_valid_r), $past(state_r == ST_EVAL),
                    "result word not produced by bucket evaluation")

endmodule
